>>> rtl/primality_trial_division_unit_macros.svh
// Assertion macros used by the datapath of the primality trial division unit.
`ifndef PRIMALITY_TRIAL_DIVISION_UNIT_MACROS_SVH
`define PRIMALITY_TRIAL_DIVISION_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptd: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define PTD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptd: next-cycle check failed");

`endif

>>> rtl/ptd_pkg.sv
// Package: widths, micro-operation codes and control structs of the unit.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int UPC_W      = 4;

  // Datapath micro-operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_INC_D,
    OP_CLR_RESULT,
    OP_SET_RESULT,
    OP_PUT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NEVER,
    C_NO_ITEM,
    C_LE_ONE,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_e;

  // One control word of the program
  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    op_e op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic le_one;
    logic div_busy;
    logic d_gt_q;
    logic rem_zero;
    logic out_busy;
  } status_t;

endpackage

>>> rtl/ptd_sequencer.sv
// Microcode sequencer: program ROM, step counter and conditional jumps.
`timescale 1ns / 1ps

module ptd_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  ptd_pkg::status_t status_i,
  output ptd_pkg::ctrl_t   ctrl_o
);
  import ptd_pkg::*;

  // Program entry points
  localparam logic [UPC_W-1:0] L_IDLE   = UPC_W'(0);
  localparam logic [UPC_W-1:0] L_DIV    = UPC_W'(2);
  localparam logic [UPC_W-1:0] L_STEP   = UPC_W'(3);
  localparam logic [UPC_W-1:0] L_FALSE  = UPC_W'(7);
  localparam logic [UPC_W-1:0] L_TRUE   = UPC_W'(8);
  localparam logic [UPC_W-1:0] L_PUT    = UPC_W'(9);

  // Program: take an item; values below two are not prime; else divide by d = 2, 3, ...
  // until d > n / d (prime) or a zero remainder (not prime), then hand over the result.
  function automatic ucode_t rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    begin
      case (addr)
        4'd0:    w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,  target: L_IDLE};
        4'd1:    w = '{op: OP_NOP,        cond: C_LE_ONE,   target: L_FALSE};
        4'd2:    w = '{op: OP_DIV_START,  cond: C_NEVER,    target: L_IDLE};
        4'd3:    w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY, target: L_STEP};
        4'd4:    w = '{op: OP_NOP,        cond: C_D_GT_Q,   target: L_TRUE};
        4'd5:    w = '{op: OP_NOP,        cond: C_REM_ZERO, target: L_FALSE};
        4'd6:    w = '{op: OP_INC_D,      cond: C_ALWAYS,   target: L_DIV};
        4'd7:    w = '{op: OP_CLR_RESULT, cond: C_ALWAYS,   target: L_PUT};
        4'd8:    w = '{op: OP_SET_RESULT, cond: C_NEVER,    target: L_IDLE};
        4'd9:    w = '{op: OP_PUT,        cond: C_OUT_BUSY, target: L_PUT};
        4'd10:   w = '{op: OP_NOP,        cond: C_ALWAYS,   target: L_IDLE};
        default: w = '{op: OP_NOP,        cond: C_ALWAYS,   target: L_IDLE};
      endcase
      return w;
    end
  endfunction

  logic [UPC_W-1:0] upc_q, upc_d;
  ucode_t           word;
  logic             taken;

  assign word = rom(upc_q);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (word.cond)
      C_ALWAYS:   taken = 1'b1;
      C_NEVER:    taken = 1'b0;
      C_NO_ITEM:  taken = !in_valid_i;
      C_LE_ONE:   taken = status_i.le_one;
      C_DIV_BUSY: taken = status_i.div_busy;
      C_D_GT_Q:   taken = status_i.d_gt_q;
      C_REM_ZERO: taken = status_i.rem_zero;
      C_OUT_BUSY: taken = status_i.out_busy;
      default:    taken = 1'b0;
    endcase
  end

  // Jump or advance
  assign upc_d     = taken ? word.target : upc_q + UPC_W'(1);
  assign ctrl_o.op = word.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= L_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

>>> rtl/ptd_datapath.sv
// Datapath: candidate and divisor registers, bit-serial divider, result register.
`timescale 1ns / 1ps
`include "primality_trial_division_unit_macros.svh"

module ptd_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ptd_pkg::ctrl_t                 ctrl_i,
  output ptd_pkg::status_t               status_o,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ptd_pkg::DATA_WIDTH-1:0] candidate_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_prime_o
);
  import ptd_pkg::*;

  logic [DATA_WIDTH-1:0] n_q, n_d;
  logic [DATA_WIDTH-1:0] d_q, d_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic                  is_prime_q, is_prime_d;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;
  logic                  out_busy;

  // One restoring division step: shift the next dividend bit in, try d
  assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, d_q};
  assign fits    = !diff[DATA_WIDTH];

  assign out_busy   = out_valid_q && !out_ready_i;
  assign in_ready_o = (ctrl_i.op == OP_ACCEPT);

  // Next values of all registers
  always_comb begin
    n_d         = n_q;
    d_d         = d_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_prime_d  = is_prime_q;
    case (ctrl_i.op)
      OP_ACCEPT: begin
        if (in_valid_i) begin
          n_d = candidate_i;
          d_d = DATA_WIDTH'(2);
        end
      end
      OP_DIV_START: begin
        rem_d = '0;
        quo_d = n_q;
        cnt_d = CNT_W'(DATA_WIDTH);
      end
      OP_DIV_STEP: begin
        if (cnt_q != '0) begin
          rem_d = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
          quo_d = {quo_q[DATA_WIDTH-2:0], fits};
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      OP_INC_D:      d_d   = d_q + DATA_WIDTH'(1);
      OP_CLR_RESULT: res_d = 1'b0;
      OP_SET_RESULT: res_d = 1'b1;
      OP_PUT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          is_prime_d  = res_q;
        end
      end
      default: ;
    endcase
  end

  // Hold control state under reset; payload registers run free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      d_q         <= DATA_WIDTH'(2);
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      d_q         <= d_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    res_q      <= res_d;
    is_prime_q <= is_prime_d;
  end

  // Status back to the sequencer
  assign status_o.le_one   = n_q[DATA_WIDTH-1] || (n_q[DATA_WIDTH-1:1] == '0);
  assign status_o.div_busy = (cnt_q != '0);
  assign status_o.d_gt_q   = (d_q > quo_q);
  assign status_o.rem_zero = (rem_q == '0);
  assign status_o.out_busy = out_busy;

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  // A finished division leaves a remainder below the divisor
  `PTD_ASSERT_IMP(a_rem_below_d, $fell(cnt_q != '0), rem_q < d_q)
  // Prime is only claimed once the divisor has passed the quotient
  `PTD_ASSERT_IMP(a_prime_bound, ctrl_i.op == OP_SET_RESULT, d_q > quo_q)
  // Output valid only rises at the hand-over step
  `PTD_ASSERT_IMP(a_no_overwrite, out_valid_d && !out_valid_q, ctrl_i.op == OP_PUT)
  // The divisor never drops below two
  `PTD_ASSERT_NXT(a_d_floor, 1'b1, d_q >= DATA_WIDTH'(2))

endmodule

>>> rtl/primality_trial_division_unit.sv
// Top level of the trial-division primality unit.
//
//   channel   valid        ready        payload
//   input     in_valid_i   in_ready_o   candidate_i  (signed, DATA_WIDTH bits)
//   output    out_valid_o  out_ready_i  is_prime_o   (1 bit)
//
// One item at a time. Each trial divisor takes one pass of the one-bit-per-cycle
// restoring divider; candidates below 2 skip the division loop and are not prime.
// Reset clears the step counter, bit counter, divisor and output valid; nothing else needs it.
// A result waiting on out_ready_i does not block the next item from being taken;
// the program only stalls at its hand-over step while the output register is full.
`timescale 1ns / 1ps

module primality_trial_division_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ptd_pkg::DATA_WIDTH-1:0] candidate_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           is_prime_o
);
  import ptd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Program sequencer
  ptd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // Datapath
  ptd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .candidate_i (candidate_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_prime_o  (is_prime_o)
  );

endmodule

>>> tb/tb_primality_trial_division_unit.sv
// Self-checking testbench for the trial-division primality unit.
`timescale 1ns / 1ps

module tb_primality_trial_division_unit;

  import ptd_pkg::DATA_WIDTH;

  localparam int unsigned STALL_LIMIT  = 6_000_000;  // well above the slowest item
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 78;

  typedef struct {
    logic [DATA_WIDTH-1:0] candidate;
    bit                    drain_first;
  } trial_item_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [DATA_WIDTH-1:0] candidate_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  is_prime_o;

  trial_item_t pending_items[$];
  logic        expected_verdicts[$];
  int unsigned failures    = 0;
  int unsigned idle_cycles = 0;

  int unsigned factor_primes[6]   = '{2, 3, 5, 7, 11, 13};
  int unsigned mid_primes[12]     = '{97, 101, 103, 127, 131, 151, 173, 181, 199, 211, 241, 251};

  primality_trial_division_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .candidate_i(candidate_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_prime_o (is_prime_o)
  );

  always #10 clk_i = ~clk_i;

  // Work out whether a candidate is prime; divisor bound kept as d <= n / d
  function automatic logic prime_verdict(input logic [DATA_WIDTH-1:0] n);
    logic [DATA_WIDTH-1:0] d;
    if (n[DATA_WIDTH-1]) return 1'b0;
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    for (d = 2; d <= n / d; d = d + 1'b1) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Keep most candidates cheap: a large prime runs the divisor loop up to its square root
  function automatic logic [DATA_WIDTH-1:0] random_candidate();
    int unsigned p;
    int unsigned q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 4095);
      4, 5:       return $urandom_range(4096, 65535);
      6:          return $urandom | 32'h8000_0000;
      7: begin
        // large multiple of a small prime: exits at its smallest factor
        p = factor_primes[$urandom_range(0, 5)];
        q = $urandom_range(2, 32'h7FFF_FFFF / p);
        return p * q;
      end
      8: begin
        // product of two mid-sized primes: runs the loop deep
        p = mid_primes[$urandom_range(0, 11)];
        q = mid_primes[$urandom_range(0, 11)];
        return p * q;
      end
      default:    return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic queue_candidate(input logic [DATA_WIDTH-1:0] value, input bit drain);
    trial_item_t item;
    item.candidate   = value;
    item.drain_first = drain;
    pending_items.push_back(item);
  endtask

  // Sender: feed items from the pending queue in bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : sender
    int unsigned           gap_left;
    int unsigned           burst_left;
    logic                  valid_nxt;
    logic [DATA_WIDTH-1:0] cand_nxt;
    trial_item_t           item;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      candidate_i <= '0;
      gap_left    = 0;
      burst_left  = 0;
    end else begin
      valid_nxt = in_valid_i;
      cand_nxt  = candidate_i;
      if (in_valid_i && in_ready_o) begin
        expected_verdicts.push_back(prime_verdict(candidate_i));
        valid_nxt = 1'b0;
      end
      if (!valid_nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain_first && expected_verdicts.size() > 0)) begin
          item      = pending_items.pop_front();
          cand_nxt  = item.candidate;
          valid_nxt = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // start a new burst; some bursts run with no gap at all
            burst_left = $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i  <= valid_nxt;
      candidate_i <= cand_nxt;
    end
  end

  // Receiver: stall on a 32-bit pattern, re-drawn at each wrap
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    logic [31:0] stall_pattern;
    logic [4:0]  pattern_pos;
    if (!rst_ni) begin
      out_ready_i   <= 1'b0;
      stall_pattern = '1;
      pattern_pos   = '0;
    end else begin
      if (pattern_pos == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '1;
          1:       stall_pattern = $urandom;
          2:       stall_pattern = $urandom & $urandom;
          default: stall_pattern = $urandom | $urandom;
        endcase
      end
      out_ready_i <= stall_pattern[pattern_pos];
      pattern_pos = pattern_pos + 1'b1;
    end
  end

  // Check each returned item against the oldest expected verdict
  always @(posedge clk_i) begin : verdict_check
    logic exp_prime;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("is_prime: no item expected, actual %0b", is_prime_o);
        failures++;
      end else begin
        exp_prime = expected_verdicts.pop_front();
        if (is_prime_o !== exp_prime) begin
          $error("is_prime: expected %0b, actual %0b", exp_prime, is_prime_o);
          failures++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int i;
    // Directed: sign extremes, values below two, two itself, squares of primes,
    // mid-sized primes and the largest positive value, which is prime
    queue_candidate(32'h8000_0000, 1'b0);
    queue_candidate(32'hFFFF_FFFF, 1'b0);
    queue_candidate(32'hC000_0001, 1'b0);
    queue_candidate(0, 1'b0);
    queue_candidate(1, 1'b0);
    queue_candidate(2, 1'b0);
    queue_candidate(3, 1'b0);
    queue_candidate(4, 1'b0);
    queue_candidate(5, 1'b0);
    queue_candidate(9, 1'b0);
    queue_candidate(25, 1'b0);
    queue_candidate(49, 1'b0);
    queue_candidate(32761, 1'b0);
    queue_candidate(10403, 1'b0);
    queue_candidate(65521, 1'b0);
    queue_candidate(65537, 1'b0);
    queue_candidate(1_000_003, 1'b0);
    queue_candidate(32'h7FFF_FFFE, 1'b0);
    queue_candidate(32'h7FFF_FFFF, 1'b1);
    queue_candidate(46340 * 46340, 1'b1);
    queue_candidate(32'h5555_5555, 1'b0);
    queue_candidate(32'h2AAA_AAAA, 1'b0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      queue_candidate(random_candidate(), $urandom_range(0, 19) == 0);
    end

    // Hold reset low at start, then release it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_verdicts.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
